// File: design/lbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and constants of the LED blink controller.
// ----------------------------------------------------------------------------
package lbc_pkg;

	localparam int unsigned PERIOD_W = 13;
	localparam int unsigned HOLD_W   = 8;
	localparam int unsigned BLINK_W  = 8;
	localparam int unsigned MODE_W   = 3;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [PERIOD_W-1:0] PERIOD_MAX    = PERIOD_W'(5000);
	localparam logic [PERIOD_W-1:0] PERIOD_STEP   = PERIOD_W'(50);
	localparam logic [HOLD_W-1:0]   HOLD_REPEAT   = HOLD_W'(200);
	localparam logic [BLINK_W-1:0]  BLINK_FOREVER = 8'hff;

	localparam logic [CFG_IDX_W-1:0] REG_LED_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_TOTAL = 2'd1;

	typedef enum logic [MODE_W-1:0] {
		MODE_IDLE       = 3'd0,
		MODE_OFF        = 3'd1,
		MODE_ON         = 3'd2,
		MODE_BLINK_CNT  = 3'd3,
		MODE_BLINK_CONT = 3'd4
	} lbc_mode_t;

	typedef struct packed {
		logic                  mode_we;
		logic                  total_we;
		logic [CFG_DATA_W-1:0] data;
	} lbc_cfg_t;

	typedef struct packed {
		logic                led_level;
		logic [PERIOD_W-1:0] blink_interval;
	} lbc_res_t;

	// One period step: adds the step while below the maximum and clamps there.
	function automatic logic [PERIOD_W-1:0] bump_period(input logic [PERIOD_W-1:0] p);
		logic [PERIOD_W:0] sum;
		logic [PERIOD_W-1:0] res;
		sum = {1'b0, p} + {1'b0, PERIOD_STEP};
		res = p;
		if (p < PERIOD_MAX) begin
			if (sum > {1'b0, PERIOD_MAX}) begin
				res = PERIOD_MAX;
			end else begin
				res = sum[PERIOD_W-1:0];
			end
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// File: design/lbc_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_core
// Per-tick state of the controller: tick counter, button handling, period
// and LED drive, updated once for each accepted item.
// ----------------------------------------------------------------------------
module lbc_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step_en,
	input  wire logic              button_level,
	input  wire lbc_pkg::lbc_cfg_t cfg,
	output lbc_pkg::lbc_res_t      res
);

	lbc_pkg::lbc_mode_t                  mode_q;
	logic [lbc_pkg::PERIOD_W-1:0]        tick_q;
	logic [lbc_pkg::PERIOD_W-1:0]        period_q;
	logic                                pending_q;
	logic [lbc_pkg::BLINK_W-1:0]         blinks_q;
	logic                                led_q;
	logic                                prev_q;
	logic                                down_q;
	logic [lbc_pkg::HOLD_W-1:0]          hold_q;

	logic [lbc_pkg::PERIOD_W-1:0] tick_inc, tick_d, period_a, period_d;
	logic                         pending_a, pending_d, led_d, down_d;
	logic [lbc_pkg::HOLD_W-1:0]   hold_a, hold_inc, hold_d;
	logic [lbc_pkg::BLINK_W-1:0]  blinks_d;
	logic                         press, release_edge;

	always_comb begin
		tick_inc  = tick_q + lbc_pkg::PERIOD_W'(1);
		tick_d    = tick_inc;
		pending_a = pending_q;
		if (tick_inc >= period_q) begin
			tick_d    = '0;
			pending_a = 1'b1;
		end

		press        = prev_q & ~button_level;
		release_edge = ~prev_q & button_level;
		period_a     = press ? lbc_pkg::bump_period(period_q) : period_q;
		down_d       = press ? 1'b1 : (release_edge ? 1'b0 : down_q);
		hold_a       = (press || release_edge) ? '0 : hold_q;
		hold_inc     = hold_a + lbc_pkg::HOLD_W'(1);
		hold_d       = hold_a;
		period_d     = period_a;
		if (down_d) begin
			hold_d = hold_inc;
			if (hold_inc >= lbc_pkg::HOLD_REPEAT) begin
				period_d = lbc_pkg::bump_period(period_a);
				hold_d   = '0;
			end
		end

		led_d     = led_q;
		blinks_d  = blinks_q;
		pending_d = pending_a;
		case (mode_q)
			lbc_pkg::MODE_OFF: led_d = 1'b0;
			lbc_pkg::MODE_ON:  led_d = 1'b1;
			lbc_pkg::MODE_BLINK_CNT, lbc_pkg::MODE_BLINK_CONT: begin
				if (pending_a) begin
					if (blinks_q != '0) begin
						led_d = ~led_q;
						if (blinks_q != lbc_pkg::BLINK_FOREVER) begin
							blinks_d = blinks_q - lbc_pkg::BLINK_W'(1);
						end
					end
					pending_d = 1'b0;
				end
			end
			default: led_d = led_q;
		endcase

		res.led_level      = led_d;
		res.blink_interval = period_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= lbc_pkg::MODE_OFF;
			tick_q    <= '0;
			period_q  <= '0;
			pending_q <= 1'b0;
			blinks_q  <= '0;
			led_q     <= 1'b0;
			prev_q    <= 1'b1;
			down_q    <= 1'b0;
			hold_q    <= '0;
		end else begin
			if (cfg.mode_we) begin
				mode_q <= lbc_pkg::lbc_mode_t'(cfg.data[lbc_pkg::MODE_W-1:0]);
			end
			if (step_en) begin
				tick_q    <= tick_d;
				period_q  <= period_d;
				pending_q <= pending_d;
				led_q     <= led_d;
				prev_q    <= button_level;
				down_q    <= down_d;
				hold_q    <= hold_d;
				blinks_q  <= blinks_d;
			end
			if (cfg.total_we) begin
				blinks_q <= cfg.data[lbc_pkg::BLINK_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

// File: design/led_blink_controller_with_button_rate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_blink_controller_with_button_rate
// Each input item is one timer tick with the active-low button level; each
// tick yields one result item with the LED drive and the blink period.
//
// The input channel (in_valid/in_ready, button_level) takes one item per
// tick. The block updates its state in the cycle of acceptance and places
// the result in an output register, shown on out_valid/out_ready with
// led_level and blink_interval in the next cycle. One item is accepted every
// cycle while the result register is empty or being drained in that cycle,
// so the sustained rate is one item per cycle while the receiver keeps up.
// When the receiver stalls, the pending result holds and in_ready drops
// until it is taken. The configuration channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data) is always ready: index 0 sets led_mode, index 1 sets
// blink_total and reloads the remaining blink count; other indexes are
// ignored. Reset clears the state (the button is taken as released),
// selects the LED-off mode and empties the result register.
// ----------------------------------------------------------------------------
module led_blink_controller_with_button_rate (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            button_level,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 led_level,
	output logic [lbc_pkg::PERIOD_W-1:0]         blink_interval,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [lbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lbc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic              accept;
	logic              out_valid_q;
	lbc_pkg::lbc_cfg_t cfg;
	lbc_pkg::lbc_res_t res;
	lbc_pkg::lbc_res_t res_q;

	assign cfg_ready    = 1'b1;
	assign in_ready     = ~out_valid_q | out_ready;
	assign accept       = in_valid & in_ready;
	assign cfg.mode_we  = cfg_valid & (cfg_index == lbc_pkg::REG_LED_MODE);
	assign cfg.total_we = cfg_valid & (cfg_index == lbc_pkg::REG_BLINK_TOTAL);
	assign cfg.data     = cfg_data;

	lbc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (accept),
		.button_level (button_level),
		.cfg          (cfg),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign led_level      = res_q.led_level;
	assign blink_interval = res_q.blink_interval;

endmodule
`default_nettype wire

// File: dv/lbc_tick_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_tick_checker
// Watches the tick, result and register channels of the LED blink controller,
// keeps its own copy of the controller state, predicts the LED level and blink
// period of every accepted tick, and compares each accepted result with the
// oldest prediction. Reports the number of mismatches and of results in flight.
// ----------------------------------------------------------------------------
module lbc_tick_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           button_level,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic                           led_level,
	input  logic [lbc_pkg::PERIOD_W-1:0]   blink_interval,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [lbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lbc_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             errors,
	output int                             pending
);
	import lbc_pkg::*;

	lbc_res_t            led_results_q[$];
	logic [MODE_W-1:0]   mode_reg;
	logic [PERIOD_W-1:0] tick_cnt;
	logic [PERIOD_W-1:0] period_now;
	logic                toggle_req;
	logic [BLINK_W-1:0]  blinks_left;
	logic                led_on;
	logic                btn_prev;
	logic                btn_held;
	logic [HOLD_W-1:0]   hold_cnt;

	function automatic logic [PERIOD_W-1:0] raised_period(input logic [PERIOD_W-1:0] p);
		int unsigned widened;
		widened = p + PERIOD_STEP;
		if (p >= PERIOD_MAX) begin
			return p;
		end
		return (widened > PERIOD_MAX) ? PERIOD_MAX : PERIOD_W'(widened);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lbc_res_t got;
		lbc_res_t want;
		if (!arst_n) begin
			mode_reg    = MODE_OFF;
			tick_cnt    = '0;
			period_now  = '0;
			toggle_req  = 1'b0;
			blinks_left = '0;
			led_on      = 1'b0;
			btn_prev    = 1'b1;
			btn_held    = 1'b0;
			hold_cnt    = '0;
			led_results_q.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got.led_level      = led_level;
				got.blink_interval = blink_interval;
				if (led_results_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual led %0d period %0d",
						$time, got.led_level, got.blink_interval);
				end else begin
					want = led_results_q.pop_front();
					if (got.led_level !== want.led_level) begin
						errors++;
						$display("%0t: led_level expected %0d, actual %0d",
							$time, want.led_level, got.led_level);
					end
					if (got.blink_interval !== want.blink_interval) begin
						errors++;
						$display("%0t: blink_interval expected %0d, actual %0d",
							$time, want.blink_interval, got.blink_interval);
					end
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LED_MODE: begin
						mode_reg = cfg_data[MODE_W-1:0];
					end
					REG_BLINK_TOTAL: begin
						blinks_left = cfg_data[BLINK_W-1:0];
					end
					default: begin
					end
				endcase
			end

			if (in_valid && in_ready) begin
				tick_cnt = tick_cnt + 1'b1;
				if (tick_cnt >= period_now) begin
					toggle_req = 1'b1;
					tick_cnt   = '0;
				end

				if (btn_prev && !button_level) begin
					period_now = raised_period(period_now);
					btn_held   = 1'b1;
					hold_cnt   = '0;
				end else if (!btn_prev && button_level) begin
					btn_held = 1'b0;
					hold_cnt = '0;
				end
				btn_prev = button_level;

				if (btn_held) begin
					hold_cnt = hold_cnt + 1'b1;
					if (hold_cnt >= HOLD_REPEAT) begin
						period_now = raised_period(period_now);
						hold_cnt   = '0;
					end
				end

				case (mode_reg)
					MODE_OFF: begin
						led_on = 1'b0;
					end
					MODE_ON: begin
						led_on = 1'b1;
					end
					MODE_BLINK_CNT, MODE_BLINK_CONT: begin
						if (toggle_req) begin
							if (blinks_left != '0) begin
								led_on = !led_on;
								if (blinks_left != BLINK_FOREVER) begin
									blinks_left = blinks_left - 1'b1;
								end
							end
							toggle_req = 1'b0;
						end
					end
					default: begin
					end
				endcase

				want.led_level      = led_on;
				want.blink_interval = period_now;
				led_results_q.push_back(want);
			end

			pending <= led_results_q.size();
		end
	end

endmodule

// File: dv/led_blink_controller_with_button_rate_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_blink_controller_with_button_rate_test
// Drives timer ticks with button patterns and register writes into the LED
// blink controller: a short directed pass over the LED modes and blink
// counts, then random taps, holds and button noise under three flow-control
// profiles, ending with a long hold and three taps. Results are
// checked by the tick checker beside the block.
// ----------------------------------------------------------------------------
module led_blink_controller_with_button_rate_test;
	import lbc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  button_level;
	logic                  out_valid;
	logic                  out_ready;
	logic                  led_level;
	logic [PERIOD_W-1:0]   blink_interval;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int          errors;
	int          pending;
	int unsigned sender_idle_pct   = 35;
	int unsigned receiver_idle_pct = 53;
	int unsigned ticks_sent        = 0;
	int unsigned cycle_count       = 0;

	led_blink_controller_with_button_rate DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.button_level   (button_level),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.led_level      (led_level),
		.blink_interval (blink_interval),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	lbc_tick_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.button_level   (button_level),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.led_level      (led_level),
		.blink_interval (blink_interval),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.errors         (errors),
		.pending        (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	task automatic send_tick(input logic level);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct) begin
			gap++;
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		button_level <= level;
		do @(posedge clk); while (!in_ready);
		ticks_sent++;
	endtask

	task automatic send_run(input logic level, input int unsigned count);
		repeat (count) send_tick(level);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] mode_data,
		input logic [CFG_DATA_W-1:0] total_data, input bit reload);
		drain();
		write_reg(REG_LED_MODE, mode_data);
		if (reload) begin
			write_reg(REG_BLINK_TOTAL, total_data);
		end
		// Indexes above the blink total are unused and must be ignored.
		write_reg(CFG_IDX_W'($urandom_range(REG_BLINK_TOTAL + 1, {CFG_IDX_W{1'b1}})),
			CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic configure_random();
		logic [MODE_W-1:0]     mode;
		logic [CFG_DATA_W-1:0] total;
		case ($urandom_range(9))
			0: mode = MODE_IDLE;
			1: mode = MODE_OFF;
			2: mode = MODE_ON;
			3: mode = MODE_W'($urandom_range(MODE_BLINK_CONT + 1, {MODE_W{1'b1}}));
			4, 5, 6: mode = MODE_BLINK_CNT;
			default: mode = MODE_BLINK_CONT;
		endcase
		case ($urandom_range(5))
			0: total = '0;
			1: total = BLINK_FOREVER;
			2: total = CFG_DATA_W'(1);
			3: total = BLINK_FOREVER - 1'b1;
			default: total = CFG_DATA_W'($urandom_range(1, 12));
		endcase
		configure({(CFG_DATA_W - MODE_W)'($urandom), mode}, total, $urandom_range(2) != 0);
	endtask

	task automatic tap();
		send_run(1'b0, $urandom_range(1, 3));
		send_run(1'b1, $urandom_range(1, 4));
	endtask

	// Mostly released button so the period stays short and the LED toggles often.
	task automatic play_quiet(input int unsigned count, input int unsigned taps);
		int unsigned target;
		target = ticks_sent + count;
		while (ticks_sent < target) begin
			configure_random();
			if (taps != 0 && $urandom_range(7) == 0) begin
				tap();
				taps--;
			end
			send_run(1'b1, $urandom_range(25, 60));
		end
	endtask

	initial begin
		int unsigned target;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		button_level <= 1'b1;
		cfg_valid    <= 1'b0;
		cfg_index    <= REG_LED_MODE;
		cfg_data     <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With a zero period every tick raises a toggle request.
		send_run(1'b1, 2);
		configure(CFG_DATA_W'(MODE_BLINK_CNT), CFG_DATA_W'(3), 1'b1);
		send_run(1'b1, 5);
		configure(CFG_DATA_W'(MODE_ON), '0, 1'b0);
		send_run(1'b1, 2);
		configure(CFG_DATA_W'(MODE_IDLE), '0, 1'b0);
		send_run(1'b1, 2);
		// All data bits set selects an undefined mode, which holds the LED.
		configure({CFG_DATA_W{1'b1}}, BLINK_FOREVER, 1'b1);
		send_run(1'b1, 2);
		configure(CFG_DATA_W'(MODE_BLINK_CONT), '0, 1'b0);
		send_run(1'b1, 4);
		configure(CFG_DATA_W'(MODE_BLINK_CNT), '0, 1'b1);
		send_run(1'b1, 2);
		send_tick(1'b0);
		send_run(1'b1, 2);

		play_quiet(300, 3);

		sender_idle_pct   = 53;
		receiver_idle_pct = 35;
		play_quiet(300, 2);
		configure_random();
		send_run(1'b0, $urandom_range(210, 260));
		send_run(1'b1, 3);

		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		target = ticks_sent + 320;
		while (ticks_sent < target) begin
			configure_random();
			repeat ($urandom_range(40, 80)) send_tick(1'($urandom_range(1)));
		end
		configure_random();
		repeat (30) begin
			send_run(1'b0, $urandom_range(1, 2));
			send_run(1'b1, $urandom_range(1, 2));
		end
		configure_random();
		send_run(1'b0, 250);
		send_run(1'b1, 20);
		repeat (3) tap();

		drain();
		repeat (5) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: led_blink_controller_with_button_rate.f
design/lbc_pkg.sv
design/lbc_core.sv
design/led_blink_controller_with_button_rate.sv
dv/lbc_tick_checker.sv
dv/led_blink_controller_with_button_rate_test.sv
